@@ rtl/arc_length_to_param_lookup_assert.svh @@
// ---------------------------------------------------------------------------
// arc length lookup assertion macros
// concurrent checks on clk, off when rst_n is low, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef ARC_LENGTH_TO_PARAM_LOOKUP_ASSERT_SVH
`define ARC_LENGTH_TO_PARAM_LOOKUP_ASSERT_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define ALPL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition never true at a clock edge outside reset
`define ALPL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ALPL_ASSERT(lbl, clk, rst_n, prop, msg)
`define ALPL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ rtl/alpl_pkg.sv @@
// ---------------------------------------------------------------------------
// alpl_pkg
// shared widths, codes and state type of the arc length lookup
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package alpl_pkg;

  localparam int LEN_W   = 32;
  localparam int PAR_W   = 17;
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 7;
  localparam int CNT_W   = 8;
  localparam int STAT_W  = 2;

  localparam logic [PAR_W-1:0] ONE_Q16 = PAR_W'(65536);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] RS_INTERP = 2'd0;
  localparam logic [STAT_W-1:0] RS_END    = 2'd1;
  localparam logic [STAT_W-1:0] RS_BELOW  = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_RESET = 8'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_END,
    ST_CHK_START,
    ST_SEARCH,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FINISH
  } alpl_state_t;

endpackage

@@ rtl/alpl_mem.sv @@
// ---------------------------------------------------------------------------
// alpl_mem
// single write port, single read port table memory, registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module alpl_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 49
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/alpl_div.sv @@
// ---------------------------------------------------------------------------
// alpl_div
// restoring divider, one quotient bit per cycle, Q0.16 fraction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module alpl_div
  import alpl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [LEN_W-1:0]  dividend,
  input  logic [LEN_W-1:0]  divisor,
  output logic              done,
  output logic [FRAC_W-1:0] quotient
);

  localparam int STEP_W = $clog2(FRAC_W);

  logic              running_r, running_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [LEN_W-1:0]  den_r;
  logic [FRAC_W-1:0] quo_r, quo_nxt;
  logic [LEN_W:0]    rem_shift;
  logic [LEN_W:0]    rem_sub;
  logic              fits;

  // dividend is below divisor, so the remainder always fits LEN_W bits
  always_comb begin
    rem_shift   = {rem_r, 1'b0};
    rem_sub     = rem_shift - {1'b0, den_r};
    fits        = (rem_shift >= {1'b0, den_r});
    running_nxt = running_r;
    done_nxt    = 1'b0;
    step_nxt    = step_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    if (start) begin
      running_nxt = 1'b1;
      step_nxt    = '0;
      rem_nxt     = dividend;
      quo_nxt     = '0;
    end else if (running_r) begin
      rem_nxt  = fits ? rem_sub[LEN_W-1:0] : rem_shift[LEN_W-1:0];
      quo_nxt  = {quo_r[FRAC_W-2:0], fits};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(FRAC_W - 1)) begin
        running_nxt = 1'b0;
        done_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      step_r    <= '0;
    end else begin
      running_r <= running_nxt;
      done_r    <= done_nxt;
      step_r    <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/arc_length_to_param_lookup.sv @@
// ---------------------------------------------------------------------------
// arc_length_to_param_lookup
// a write request is taken while idle and busy stays low
// query: a request at or above the last entry gives the end result, one below
// the first gives the below result, else a binary search reads the table on its
// one read port, then the 16-step fraction divider and two multiplies follow
// one request at a time; results cannot be stalled; sync reset clears control
// and sets entry_count to 2, table contents stay undefined until written
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arc_length_to_param_lookup_assert.svh"

module arc_length_to_param_lookup
  import alpl_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [LEN_W-1:0]  in_entry_length,
  input  logic [PAR_W-1:0]  in_entry_param,
  input  logic [LEN_W-1:0]  in_query_length,
  // result channel
  output logic              out_valid,
  output logic [PAR_W-1:0]  out_param_value,
  output logic [STAT_W-1:0] out_range_status,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_entry_count
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int IW     = (AW > IDX_W) ? AW : IDX_W;
  localparam int WORD_W = LEN_W + PAR_W;
  localparam int PROD_W = 2 * PAR_W;
  localparam int ACC_W  = PROD_W + 1;

  // control state
  alpl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  entry_count_r;
  logic              out_valid_r, out_valid_nxt;

  // query datapath
  logic [LEN_W-1:0]  q_r, q_nxt;
  logic [AW-1:0]     lo_r, lo_nxt;
  logic [AW-1:0]     hi_r, hi_nxt;
  logic [AW-1:0]     mid_r, mid_nxt;
  logic [LEN_W-1:0]  len_lo_r, len_lo_nxt;
  logic [LEN_W-1:0]  len_hi_r, len_hi_nxt;
  logic [PAR_W-1:0]  p_lo_r, p_lo_nxt;
  logic [PAR_W-1:0]  p_hi_r, p_hi_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [PAR_W-1:0]  out_param_r, out_param_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;

  // table memory port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic [LEN_W-1:0]  rd_len;
  logic [PAR_W-1:0]  rd_par;

  // misc
  logic              accept;
  logic              slot_ok;
  logic [IW-1:0]     slot_wide;
  logic [AW-1:0]     last_idx;
  logic              go_search;
  logic [AW:0]       mid_sum;
  logic              div_start;
  logic              div_done;
  logic [FRAC_W-1:0] div_quo;
  logic [LEN_W-1:0]  div_dividend;
  logic [LEN_W-1:0]  div_divisor;
  logic [PAR_W-1:0]  w_lo;
  logic [PAR_W-1:0]  mul_x;
  logic [PAR_W-1:0]  mul_y;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-FRAC_W-1:0] acc_hi;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  // ---- table writes go straight into memory at the accepting edge ----
  // slots at or above the table depth are dropped
  assign slot_wide = IW'(in_entry_index);
  assign slot_ok   = (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign mem_we    = accept & (in_operation == OP_WRITE) & slot_ok;
  assign mem_waddr = slot_wide[AW-1:0];
  assign mem_wdata = {in_entry_param, in_entry_length};

  // each memory word carries length and parameter of one slot
  assign rd_len = mem_rdata[LEN_W-1:0];
  assign rd_par = mem_rdata[WORD_W-1:LEN_W];

  alpl_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (WORD_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---- entries in use, clamped to [2, depth], as the last slot index ----
  always_comb begin
    if (32'(entry_count_r) < 32'd2) begin
      last_idx = AW'(1);
    end else if (32'(entry_count_r) > 32'(TABLE_DEPTH)) begin
      last_idx = AW'(TABLE_DEPTH - 1);
    end else begin
      last_idx = AW'(32'(entry_count_r) - 32'd1);
    end
  end

  // ---- fraction divider: (q - len_lo) / (len_hi - len_lo) in Q0.16 ----
  // the search leaves len_lo <= q < len_hi, so the divisor is nonzero
  assign div_start    = (state_r == ST_DIV_GO);
  assign div_dividend = q_r - len_lo_r;
  assign div_divisor  = len_hi_r - len_lo_r;

  alpl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---- one shared 17x17 multiplier, low weight first then high ----
  assign w_lo   = ONE_Q16 - {1'b0, frac_r};
  assign mul_x  = (state_r == ST_MUL_HI) ? p_hi_r : p_lo_r;
  assign mul_y  = (state_r == ST_MUL_HI) ? {1'b0, frac_r} : w_lo;
  assign prod   = PROD_W'(mul_x) * PROD_W'(mul_y);
  assign acc_hi = acc_r[ACC_W-1:FRAC_W];

  // ---- sequencer ----
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    out_param_nxt  = out_param_r;
    out_status_nxt = out_status_r;
    q_nxt          = q_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    len_lo_nxt     = len_lo_r;
    len_hi_nxt     = len_hi_r;
    p_lo_nxt       = p_lo_r;
    p_hi_nxt       = p_hi_r;
    frac_nxt       = frac_r;
    acc_nxt        = acc_r;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    go_search      = 1'b0;
    mid_sum        = '0;

    case (state_r)
      ST_IDLE: begin
        // a query reads the last slot in use first
        if (accept && (in_operation == OP_QUERY)) begin
          q_nxt     = in_query_length;
          hi_nxt    = last_idx;
          mem_re    = 1'b1;
          mem_raddr = last_idx;
          state_nxt = ST_CHK_END;
        end
      end

      ST_CHK_END: begin
        len_hi_nxt = rd_len;
        p_hi_nxt   = rd_par;
        // at or above the end wins over below the start
        if (q_r >= rd_len) begin
          out_valid_nxt  = 1'b1;
          out_param_nxt  = ONE_Q16;
          out_status_nxt = RS_END;
          state_nxt      = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_nxt = ST_CHK_START;
        end
      end

      ST_CHK_START: begin
        if (q_r < rd_len) begin
          out_valid_nxt  = 1'b1;
          out_param_nxt  = '0;
          out_status_nxt = RS_BELOW;
          state_nxt      = ST_IDLE;
        end else begin
          lo_nxt     = '0;
          len_lo_nxt = rd_len;
          p_lo_nxt   = rd_par;
          go_search  = 1'b1;
        end
      end

      ST_SEARCH: begin
        // keep len[lo] <= q < len[hi]
        if (q_r >= rd_len) begin
          lo_nxt     = mid_r;
          len_lo_nxt = rd_len;
          p_lo_nxt   = rd_par;
        end else begin
          hi_nxt     = mid_r;
          len_hi_nxt = rd_len;
          p_hi_nxt   = rd_par;
        end
        go_search = 1'b1;
      end

      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (div_done) begin
          frac_nxt  = div_quo;
          state_nxt = ST_MUL_LO;
        end
      end

      ST_MUL_LO: begin
        // rounding constant folded in here
        acc_nxt   = ACC_W'(prod) + ACC_W'(32768);
        state_nxt = ST_MUL_HI;
      end

      ST_MUL_HI: begin
        acc_nxt   = acc_r + ACC_W'(prod);
        state_nxt = ST_FINISH;
      end

      ST_FINISH: begin
        // a stored parameter above 1.0 can push the sum over, saturate
        out_valid_nxt  = 1'b1;
        out_status_nxt = RS_INTERP;
        if (acc_hi > (ACC_W - FRAC_W)'(ONE_Q16)) begin
          out_param_nxt = ONE_Q16;
        end else begin
          out_param_nxt = acc_hi[PAR_W-1:0];
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // next probe of the binary search, or on to the divider
    if (go_search) begin
      if ((hi_nxt - lo_nxt) > AW'(1)) begin
        mid_sum   = {1'b0, lo_nxt} + {1'b0, hi_nxt};
        mid_nxt   = mid_sum[AW:1];
        mem_re    = 1'b1;
        mem_raddr = mid_sum[AW:1];
        state_nxt = ST_SEARCH;
      end else begin
        state_nxt = ST_DIV_GO;
      end
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      entry_count_r <= COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        entry_count_r <= cfg_entry_count;
      end
    end
  end

  // ---- datapath registers, no reset needed ----
  always_ff @(posedge clk) begin
    q_r          <= q_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    len_lo_r     <= len_lo_nxt;
    len_hi_r     <= len_hi_nxt;
    p_lo_r       <= p_lo_nxt;
    p_hi_r       <= p_hi_nxt;
    frac_r       <= frac_nxt;
    acc_r        <= acc_nxt;
    out_param_r  <= out_param_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_param_value  = out_param_r;
  assign out_range_status = out_status_r;

  // ---- checks ----
  `ALPL_ASSERT(a_result_from_query, clk, rst_n, out_valid |-> $past(state_r != ST_IDLE), "result without a query in flight")
  `ALPL_ASSERT(a_single_result, clk, rst_n, out_valid |=> !out_valid, "two results for one query")
  `ALPL_ASSERT(a_probe_inside, clk, rst_n, (state_r == ST_SEARCH) |-> ((lo_r < mid_r) && (mid_r < hi_r)), "search probe outside bracket")
  `ALPL_ASSERT(a_div_done_waited, clk, rst_n, div_done |-> (state_r == ST_DIV_WAIT), "divider finished while not awaited")

endmodule
